### hdl/utf16_utf8_offset_map_defines.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 offset map: assertion macros
// Shared assertion wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef UTF16_UTF8_OFFSET_MAP_DEFINES_SVH
`define UTF16_UTF8_OFFSET_MAP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define UOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define UOM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/uom_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 offset map: package
// Command codes, surrogate limits and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package uom_pkg;

  localparam int unsigned DEF_MAX_UNITS = 1024;

  localparam logic [2:0] MODE_START     = 3'd0;
  localparam logic [2:0] MODE_APPEND    = 3'd1;
  localparam logic [2:0] MODE_END       = 3'd2;
  localparam logic [2:0] MODE_U8_TO_U16 = 3'd3;
  localparam logic [2:0] MODE_U16_TO_U8 = 3'd4;

  localparam logic [15:0] HI_SURR_LO     = 16'hd800;
  localparam logic [15:0] HI_SURR_HI     = 16'hdbff;
  localparam logic [15:0] LO_SURR_LO     = 16'hdc00;
  localparam logic [15:0] LO_SURR_HI     = 16'hdfff;
  localparam logic [15:0] ONE_BYTE_MAX   = 16'h007f;
  localparam logic [15:0] TWO_BYTE_MAX   = 16'h07ff;

  localparam logic [2:0] LONE_SURR_BYTES = 3'd3;
  localparam logic [2:0] PAIR_BYTES      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the input transaction
    logic decode;      // first cycle of a transaction
    logic clear;       // start a new string
    logic flush_load;  // load the byte run of a pending high surrogate
    logic emit_step;   // write one byte-table entry
    logic mark;        // record the unit's byte offset and count it
    logic mark_load;   // load the byte run of the unit just marked
    logic rd_query;    // issue the table reads of a query
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       pending;
    logic       cu_low;
    logic       nb_zero;
    logic       emit_last;
  } stat_t;

  // UTF-8 length of a single unit; a high surrogate emits nothing yet.
  function automatic logic [2:0] byte_len(input logic [15:0] cu);
    logic [2:0] n;
    if (cu >= HI_SURR_LO && cu <= HI_SURR_HI) begin
      n = 3'd0;
    end else if (cu <= ONE_BYTE_MAX) begin
      n = 3'd1;
    end else if (cu <= TWO_BYTE_MAX) begin
      n = 3'd2;
    end else begin
      n = 3'd3;
    end
    return n;
  endfunction

endpackage

### hdl/uom_ctrl.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 offset map: controller
// Sequences each transaction through decode, byte writes, marking and result.
// ----------------------------------------------------------------------------
`include "utf16_utf8_offset_map_defines.svh"

module uom_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  uom_pkg::stat_t stat,
  output uom_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_FLUSH    = 3'd2;
  localparam logic [2:0] S_MARK     = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state, state_next;
  logic       pair, pair_next;

  assign busy = !(state == S_IDLE || state == S_DONE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state;
    pair_next  = pair;
    cmd        = '0;
    cmd.latch  = start && !busy;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.decode = 1'b1;
        pair_next  = 1'b0;
        state_next = S_DONE;
        unique case (stat.mode)
          uom_pkg::MODE_START: begin
            cmd.clear = 1'b1;
          end
          uom_pkg::MODE_APPEND: begin
            if (!stat.full) begin
              if (stat.pending) begin
                cmd.flush_load = 1'b1;
                if (stat.cu_low) begin
                  // Surrogate pair: mark first, then write all four bytes.
                  pair_next  = 1'b1;
                  state_next = S_MARK;
                end else begin
                  state_next = S_FLUSH;
                end
              end else begin
                state_next = S_MARK;
              end
            end
          end
          uom_pkg::MODE_END: begin
            if (stat.pending) begin
              cmd.flush_load = 1'b1;
              state_next     = S_EMIT;
            end
          end
          uom_pkg::MODE_U8_TO_U16, uom_pkg::MODE_U16_TO_U8: begin
            cmd.rd_query = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_FLUSH: begin
        cmd.emit_step = 1'b1;
        if (stat.emit_last) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (pair) begin
          state_next = S_EMIT;
        end else begin
          cmd.mark_load = 1'b1;
          state_next    = stat.nb_zero ? S_DONE : S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.emit_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = start ? S_DISPATCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pair  <= 1'b0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
    end
  end

  `UOM_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `UOM_ASSERT_NEXT(a_drop_quick, state == S_DISPATCH && stat.mode == uom_pkg::MODE_APPEND && stat.full, done, "dropped unit did not complete at once")

endmodule

### hdl/uom_dp.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 offset map: datapath
// Counters, pending flag, both offset tables and the query result selection.
// ----------------------------------------------------------------------------
`include "utf16_utf8_offset_map_defines.svh"

module uom_dp #(
  parameter int unsigned MAX_UNITS = uom_pkg::DEF_MAX_UNITS
) (
  input  logic               clk,
  input  logic               rst,
  input  uom_pkg::cmd_t      cmd,
  output uom_pkg::stat_t     stat,
  input  logic [2:0]         mode,
  input  logic [15:0]        code_unit,
  input  logic signed [15:0] query_offset,
  output logic signed [15:0] result_offset,
  output logic               status
);

  localparam int unsigned BYTE_DEPTH = 3 * MAX_UNITS;
  localparam int unsigned UAW = $clog2(MAX_UNITS);
  localparam int unsigned UCW = $clog2(MAX_UNITS + 1);
  localparam int unsigned BAW = $clog2(BYTE_DEPTH);
  localparam int unsigned BCW = $clog2(BYTE_DEPTH + 1);
  localparam int unsigned CW  = (BCW > 15) ? BCW : 15;

  logic [2:0]     mode_q;
  logic [15:0]    cu_q;
  logic [15:0]    qo_q;
  logic [UCW-1:0] uc;
  logic [BCW-1:0] bc;
  logic           pending;
  logic           drop;
  logic [2:0]     emit_left;
  logic [UAW-1:0] emit_unit;

  logic [BCW-1:0] u2b_mem [MAX_UNITS];
  logic [UAW-1:0] b2u_mem [BYTE_DEPTH];
  logic [BCW-1:0] u2b_rd;
  logic [UAW-1:0] b2u_rd;

  logic [UCW-1:0] uc_prev;
  logic           full;
  logic           cu_low;
  logic [2:0]     nb;
  logic           bc_ok;
  logic [CW-1:0]  u_ext;
  logic [CW-1:0]  uc_ext;
  logic [CW-1:0]  bc_ext;
  logic           in_b;
  logic           in_u;
  logic [15:0]    res;

  assign uc_prev = uc - UCW'(1);
  assign full    = (uc >= UCW'(MAX_UNITS));
  assign cu_low  = (cu_q >= uom_pkg::LO_SURR_LO) && (cu_q <= uom_pkg::LO_SURR_HI);
  assign nb      = uom_pkg::byte_len(cu_q);
  assign bc_ok   = (bc < BCW'(BYTE_DEPTH));
  assign u_ext   = CW'(qo_q[14:0]);
  assign uc_ext  = CW'(uc);
  assign bc_ext  = CW'(bc);
  assign in_b    = (u_ext < bc_ext);
  assign in_u    = (u_ext < uc_ext);

  assign stat.mode      = mode_q;
  assign stat.full      = full;
  assign stat.pending   = pending;
  assign stat.cu_low    = cu_low;
  assign stat.nb_zero   = (nb == 3'd0);
  assign stat.emit_last = (emit_left == 3'd1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= mode;
      cu_q   <= code_unit;
      qo_q   <= query_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uc        <= '0;
      bc        <= '0;
      pending   <= 1'b0;
      drop      <= 1'b0;
      emit_left <= '0;
    end else begin
      if (cmd.decode) begin
        drop <= (mode_q == uom_pkg::MODE_APPEND) && full;
      end
      if (cmd.clear) begin
        uc      <= '0;
        bc      <= '0;
        pending <= 1'b0;
      end
      if (cmd.flush_load) begin
        // A low surrogate after the pending high one completes a pair.
        emit_left <= (mode_q == uom_pkg::MODE_APPEND && cu_low) ?
                     uom_pkg::PAIR_BYTES : uom_pkg::LONE_SURR_BYTES;
        emit_unit <= uc_prev[UAW-1:0];
        pending   <= 1'b0;
      end
      if (cmd.mark) begin
        uc      <= uc + UCW'(1);
        pending <= (nb == 3'd0) && !cu_low;
      end
      if (cmd.mark_load) begin
        emit_left <= nb;
        emit_unit <= uc[UAW-1:0];
      end
      if (cmd.emit_step) begin
        emit_left <= emit_left - 3'd1;
        if (bc_ok) begin
          bc <= bc + BCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      u2b_mem[uc[UAW-1:0]] <= bc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_query && in_u) begin
      u2b_rd <= u2b_mem[u_ext[UAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step && bc_ok) begin
      b2u_mem[bc[BAW-1:0]] <= emit_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_query && in_b) begin
      b2u_rd <= b2u_mem[u_ext[BAW-1:0]];
    end
  end

  // With no multibyte characters the offsets coincide, negative ones included.
  always_comb begin
    res = '0;
    if (mode_q == uom_pkg::MODE_U8_TO_U16 || mode_q == uom_pkg::MODE_U16_TO_U8) begin
      if (bc_ext == uc_ext) begin
        res = qo_q;
      end else if (qo_q[15]) begin
        res = '0;
      end else if (mode_q == uom_pkg::MODE_U8_TO_U16) begin
        res = in_b ? 16'(b2u_rd) : 16'(uc);
      end else begin
        res = in_u ? 16'(u2b_rd) : 16'(bc);
      end
    end
  end

  assign result_offset = $signed(res);
  assign status        = drop;

  `UOM_ASSERT(a_pending_has_unit, pending |-> (uc != '0), "pending high surrogate with an empty store")
  `UOM_ASSERT(a_bytes_bounded, 32'(bc) <= 32'(uc) * 32'd3, "byte count exceeds three bytes per unit")
  `UOM_ASSERT(a_emit_has_work, cmd.emit_step |-> (emit_left != 3'd0), "byte write with no bytes left in the run")
  `UOM_ASSERT(a_mark_not_full, cmd.mark |-> !full, "unit stored while the store is full")

endmodule

### hdl/utf16_utf8_offset_map.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 offset map
// Append runs dispatch, mark and byte writes, one byte-table write per cycle
// (a flushed lone high surrogate writes its bytes first; a dropped unit goes
// straight to done). End string writes the pending bytes; other modes end
// after dispatch. The next transaction is taken in the done cycle. Reset is
// synchronous: it empties the string and clears pending, status and the FSM.
// ----------------------------------------------------------------------------
module utf16_utf8_offset_map #(
  parameter int unsigned MAX_UNITS = uom_pkg::DEF_MAX_UNITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [15:0]        code_unit,
  input  logic signed [15:0] query_offset,
  output logic               done,
  output logic signed [15:0] result_offset,
  output logic               status
);

  uom_pkg::cmd_t  cmd;
  uom_pkg::stat_t stat;

  uom_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  uom_dp #(
    .MAX_UNITS (MAX_UNITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .code_unit     (code_unit),
    .query_offset  (query_offset),
    .result_offset (result_offset),
    .status        (status)
  );

endmodule
